@@ rtl/core/evfe_pkg.sv @@
`default_nettype none
package evfe_pkg;

    typedef enum logic [2:0] {
        PH_ID    = 3'd0,
        PH_SIZE  = 3'd1,
        PH_VALUE = 3'd2,
        PH_BLOCK = 3'd3,
        PH_CODEC = 3'd4,
        PH_SKIP  = 3'd5
    } phase_t;

    localparam logic [63:0] ID_SEGMENT    = 64'h18538067;
    localparam logic [63:0] ID_INFO       = 64'h1549A966;
    localparam logic [63:0] ID_SCALE      = 64'h2AD7B1;
    localparam logic [63:0] ID_CLUSTER    = 64'h1F43B675;
    localparam logic [63:0] ID_TIMECODE   = 64'hE7;
    localparam logic [63:0] ID_SIMPLEBLK  = 64'hA3;
    localparam logic [63:0] ID_TRACKS     = 64'h1654AE6B;
    localparam logic [63:0] ID_TRACKENTRY = 64'hAE;
    localparam logic [63:0] ID_VIDEO      = 64'hE0;
    localparam logic [63:0] ID_PIXWIDTH   = 64'hB0;
    localparam logic [63:0] ID_PIXHEIGHT  = 64'hBA;
    localparam logic [63:0] ID_CODECPRIV  = 64'h63A2;
    localparam logic [7:0]  TRACK_ONE     = 8'd129;
    localparam logic [63:0] US_PER_MS     = 64'd1000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } in_word_t;

    typedef struct packed {
        logic [63:0] presentation_time;
        logic [63:0] system_time;
        logic [39:0] payload_offset;
        logic [55:0] payload_length;
        logic [39:0] cluster_start;
        logic        key_flag;
        logic        wrong_track;
        logic [31:0] pixel_width;
        logic [31:0] pixel_height;
        logic [39:0] codec_data_offset;
        logic [55:0] codec_data_length;
        logic        stream_done;
    } out_word_t;

endpackage
`default_nettype wire

@@ rtl/core/evfe_if.sv @@
`default_nettype none
interface evfe_in_if;
    logic                valid;
    logic                ready;
    evfe_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface evfe_out_if;
    logic                valid;
    logic                ready;
    evfe_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/ebml_video_frame_extractor_unit.sv @@
`default_nettype none
// Byte-serial Matroska frame extractor. One container byte is taken per clock
// while the result queue has room; a byte is parsed in the cycle it is taken.
// A frame record goes through a time pipeline (timecode sum, scale/1000 by a
// reciprocal multiply, 64-bit product built from 32-bit partial products),
// so it is written to the output queue from the last stage, once its product
// is ready. Records leave through a four-entry queue; the input stalls while
// queued records plus records in flight exceed two, so a byte that yields
// both a frame and a done record always finds room. End of stream on a byte
// adds a done record after any frame record that byte completes, and returns
// parsing and the byte position to reset.
module ebml_video_frame_extractor_unit #(
    parameter int OFFSET_BITS = 40
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    evfe_in_if.sink          in_ch,
    evfe_out_if.source       out_ch
);
    import evfe_pkg::*;

    localparam int PL = 6;  // pipeline depth of a record
    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    logic [63:0] offset_reg;

    // parse state
    phase_t      phase_reg;
    logic [3:0]  fcnt_reg, ftot_reg;
    logic [63:0] id_reg, size_reg, val_reg;
    logic [55:0] rem_reg;
    logic [OFFSET_BITS-1:0] pos_reg, estart_reg, clus_reg, coff_reg;
    logic [63:0] scale_reg, ctc_reg;
    logic [31:0] wid_reg, hgt_reg, bhdr_reg;
    logic [55:0] clen_reg;

    logic accept;
    assign accept = in_ch.valid && in_ch.ready;

    logic [7:0] b;
    logic       eos;
    assign b   = in_ch.data.data_byte;
    assign eos = in_ch.data.end_of_stream;

    logic [OFFSET_BITS-1:0] next_pos;
    assign next_pos = pos_reg + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    // vint length from leading zeros of a nonzero first byte
    function automatic logic [3:0] vlen(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 7; i >= 1; i--)
            if (v[i] && n == 4'd8)
                n = 4'(8 - i);
        return n;
    endfunction

    // strip the marker: the marker of an n-byte vint sits at bit 8n-n
    function automatic logic [63:0] strip(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] r;
        r = v;
        r[7*n] = 1'b0;
        return r;
    endfunction

    logic [63:0] acc_c;
    logic        fdone_c;
    logic [3:0]  cnt_c;
    logic [55:0] rem_dec;
    assign rem_dec = rem_reg - 56'd1;

    always_comb
    begin
        logic [63:0] a;
        a = (phase_reg == PH_ID) ? id_reg : size_reg;
        if (fcnt_reg == 4'd0)
        begin
            acc_c   = {56'd0, b};
            cnt_c   = (b == 8'd0) ? 4'd0 : 4'd1;
            fdone_c = (b == 8'd0) || (vlen(b) == 4'd1);
        end
        else
        begin
            acc_c   = {a[55:0], b};
            cnt_c   = fcnt_reg + 4'd1;
            fdone_c = (fcnt_reg + 4'd1) >= ftot_reg;
        end
    end

    logic        emit;
    logic [31:0] bhdr_c;
    logic [55:0] size_dec4;
    assign size_dec4 = size_reg[55:0] - 56'd4;

    always_comb
    begin
        bhdr_c = bhdr_reg;
        if (size_reg[55:0] - rem_reg < 56'd4)
            bhdr_c = {bhdr_reg[23:0], b};
    end
    assign emit = accept && phase_reg == PH_BLOCK && rem_dec == 56'd0
               && size_reg[55:0] >= 56'd4;

    // parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            phase_reg  <= PH_ID;
            fcnt_reg   <= '0;
            ftot_reg   <= '0;
            id_reg     <= '0;
            size_reg   <= '0;
            val_reg    <= '0;
            rem_reg    <= '0;
            pos_reg    <= '0;
            estart_reg <= '0;
            clus_reg   <= '0;
            coff_reg   <= '0;
            scale_reg  <= '0;
            ctc_reg    <= '0;
            wid_reg    <= '0;
            hgt_reg    <= '0;
            bhdr_reg   <= '0;
            clen_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                offset_reg <= cfg_wdata;
            if (accept)
            begin
                pos_reg <= next_pos;
                case (phase_reg)
                    PH_ID:
                    begin
                        if (fcnt_reg == 4'd0)
                        begin
                            estart_reg <= pos_reg;
                            if (b != 8'd0)
                                ftot_reg <= vlen(b);
                        end
                        id_reg <= acc_c;
                        if (fdone_c)
                        begin
                            fcnt_reg  <= '0;
                            phase_reg <= PH_SIZE;
                        end
                        else
                            fcnt_reg <= cnt_c;
                    end
                    PH_SIZE:
                    begin
                        logic [3:0]  n;
                        logic [63:0] sz;
                        n = (fcnt_reg == 4'd0) ? vlen(b) : ftot_reg;
                        if (fcnt_reg == 4'd0 && b != 8'd0)
                            ftot_reg <= vlen(b);
                        sz = strip(acc_c, n);
                        sz[63:56] = 8'd0;
                        if (acc_c == 64'd0)
                            sz = 64'd0;
                        if (!fdone_c)
                        begin
                            size_reg <= acc_c;
                            fcnt_reg <= cnt_c;
                        end
                        else
                        begin
                            size_reg <= sz;
                            rem_reg  <= sz[55:0];
                            fcnt_reg <= '0;
                            if (id_reg == ID_SEGMENT || id_reg == ID_INFO
                                || id_reg == ID_CLUSTER || id_reg == ID_TRACKS
                                || id_reg == ID_TRACKENTRY || id_reg == ID_VIDEO)
                            begin
                                if (id_reg == ID_CLUSTER)
                                    clus_reg <= estart_reg;
                                phase_reg <= PH_ID;
                            end
                            else if (id_reg == ID_SCALE || id_reg == ID_TIMECODE
                                || id_reg == ID_PIXWIDTH || id_reg == ID_PIXHEIGHT)
                            begin
                                val_reg <= '0;
                                if (sz == 64'd0)
                                begin
                                    if (id_reg == ID_SCALE)     scale_reg <= '0;
                                    if (id_reg == ID_TIMECODE)  ctc_reg   <= '0;
                                    if (id_reg == ID_PIXWIDTH)  wid_reg   <= '0;
                                    if (id_reg == ID_PIXHEIGHT) hgt_reg   <= '0;
                                    phase_reg <= PH_ID;
                                end
                                else
                                    phase_reg <= PH_VALUE;
                            end
                            else if (id_reg == ID_CODECPRIV)
                            begin
                                estart_reg <= next_pos;
                                if (sz == 64'd0)
                                begin
                                    coff_reg  <= next_pos;
                                    clen_reg  <= '0;
                                    phase_reg <= PH_ID;
                                end
                                else
                                    phase_reg <= PH_CODEC;
                            end
                            else if (id_reg == ID_SIMPLEBLK)
                            begin
                                estart_reg <= next_pos;
                                bhdr_reg   <= '0;
                                phase_reg  <= (sz == 64'd0) ? PH_ID : PH_BLOCK;
                            end
                            else
                                phase_reg <= (sz == 64'd0) ? PH_ID : PH_SKIP;
                        end
                    end
                    PH_VALUE:
                    begin
                        logic [63:0] v;
                        v = {val_reg[55:0], b};
                        val_reg <= v;
                        rem_reg <= rem_dec;
                        if (rem_dec == 56'd0)
                        begin
                            if (id_reg == ID_SCALE)     scale_reg <= v;
                            if (id_reg == ID_TIMECODE)  ctc_reg   <= v;
                            if (id_reg == ID_PIXWIDTH)  wid_reg   <= v[31:0];
                            if (id_reg == ID_PIXHEIGHT) hgt_reg   <= v[31:0];
                            phase_reg <= PH_ID;
                        end
                    end
                    PH_CODEC:
                    begin
                        rem_reg <= rem_dec;
                        if (rem_dec == 56'd0)
                        begin
                            coff_reg  <= estart_reg;
                            clen_reg  <= size_reg[55:0];
                            phase_reg <= PH_ID;
                        end
                    end
                    PH_BLOCK:
                    begin
                        bhdr_reg <= bhdr_c;
                        rem_reg  <= rem_dec;
                        if (rem_dec == 56'd0)
                            phase_reg <= PH_ID;
                    end
                    PH_SKIP:
                    begin
                        rem_reg <= rem_dec;
                        if (rem_dec == 56'd0)
                            phase_reg <= PH_ID;
                    end
                    default:
                    begin
                        // unused code acts as expecting an id on a fresh field
                        phase_reg <= PH_SIZE;
                        estart_reg <= pos_reg;
                        id_reg <= {56'd0, b};
                        fcnt_reg <= '0;
                        if (b != 8'd0 && vlen(b) != 4'd1)
                        begin
                            phase_reg <= PH_ID;
                            ftot_reg  <= vlen(b);
                            fcnt_reg  <= 4'd1;
                        end
                        else if (b != 8'd0)
                            ftot_reg <= vlen(b);
                    end
                endcase
                if (eos)
                begin
                    phase_reg  <= PH_ID;
                    fcnt_reg   <= '0;
                    ftot_reg   <= '0;
                    id_reg     <= '0;
                    size_reg   <= '0;
                    rem_reg    <= '0;
                    val_reg    <= '0;
                    pos_reg    <= '0;
                    estart_reg <= '0;
                    bhdr_reg   <= '0;
                end
            end
        end
    end

    // record pipeline: stage payload per stage, valid bits per stage
    typedef struct packed {
        logic        frame;
        logic        done;
    } tag_t;

    tag_t        tag_reg [PL];
    out_word_t   rec_reg [PL];
    logic [63:0] tsum_reg;
    logic [63:0] sc_reg [3];
    logic [63:0] k_reg;        // scale/1000
    logic [63:0] qa_reg;       // reciprocal product
    logic [63:0] pl_reg, ph_reg, pm_reg;

    // stage 0: capture the record, timecode sum
    out_word_t rec0;
    always_comb
    begin
        logic [63:0] tc;
        tc = {{48{bhdr_c[23]}}, bhdr_c[23:8]};
        rec0 = '0;
        rec0.payload_offset    = 40'(estart_reg + OFFSET_BITS'(4));
        rec0.payload_length    = size_dec4;
        rec0.cluster_start     = 40'(clus_reg);
        rec0.key_flag          = bhdr_c[7];
        rec0.wrong_track       = bhdr_c[31:24] != TRACK_ONE;
        rec0.pixel_width       = wid_reg;
        rec0.pixel_height      = hgt_reg;
        rec0.codec_data_offset = 40'(coff_reg);
        rec0.codec_data_length = clen_reg;
        rec0.presentation_time = ctc_reg + tc;
    end

    // scale/1000 = floor(s/8 / 125); s/8 < 2^61, reciprocal ceil(2^68/125)
    // split into partial products over the stages
    localparam logic [63:0] RECIP = 64'h20C49BA5E353F7CF; // ceil(2^68/125)

    logic [60:0] s8;
    logic [127:0] qprod;
    logic [63:0] qv;
    logic [63:0] remv;
    assign s8 = sc_reg[0][63:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PL; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            tag_reg[0] <= '{frame: emit, done: accept && eos};
            for (int i = 1; i < PL; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    // partial products of the reciprocal multiply and the final product
    logic [63:0] pp_reg [4];
    always_ff @(posedge clk)
    begin
        rec_reg[0]  <= rec0;
        sc_reg[0]   <= scale_reg;
        for (int i = 1; i < PL; i++)
            rec_reg[i] <= rec_reg[i-1];
        sc_reg[1] <= sc_reg[0];
        sc_reg[2] <= sc_reg[1];
        // stage 1: 32x32 pieces of s8 * RECIP
        pp_reg[0] <= {32'd0, s8[31:0]} * {32'd0, RECIP[31:0]};
        pp_reg[1] <= {32'd0, s8[31:0]} * {32'd0, RECIP[63:32]};
        pp_reg[2] <= {35'd0, s8[60:32]} * {32'd0, RECIP[31:0]};
        pp_reg[3] <= {35'd0, s8[60:32]} * {32'd0, RECIP[63:32]};
        // stage 2: sum to quotient
        qa_reg <= qv;
        // stage 3: correction against the true value
        k_reg <= (remv >= 64'd125) ? qa_reg + 64'd1 : qa_reg;
        // stages 4..5: product of time sum and k, low 64 bits
        pl_reg <= {32'd0, rec_reg[3].presentation_time[31:0]} * {32'd0, k_reg[31:0]};
        pm_reg <= 64'({32'd0, rec_reg[3].presentation_time[63:32]} * {32'd0, k_reg[31:0]});
        ph_reg <= 64'({32'd0, rec_reg[3].presentation_time[31:0]} * {32'd0, k_reg[63:32]});
        tsum_reg <= pl_reg + {pm_reg[31:0] + ph_reg[31:0], 32'd0};
    end

    assign qprod = {64'd0, pp_reg[0]} + ({64'd0, pp_reg[1]} << 32)
                 + ({64'd0, pp_reg[2]} << 32) + ({64'd0, pp_reg[3]} << 64);
    assign qv = 64'(qprod[127:68]);
    assign remv = {3'd0, sc_reg[2][63:3]} - qa_reg * 64'd125;

    // final record at the last stage (product ready)
    out_word_t fin_c;
    logic fin_frame, fin_done;
    assign fin_frame = tag_reg[PL-1].frame;
    assign fin_done  = tag_reg[PL-1].done;
    always_comb
    begin
        fin_c = rec_reg[PL-1];
        fin_c.presentation_time = tsum_reg;
        fin_c.system_time = (offset_reg != 64'd0) ? tsum_reg + offset_reg : 64'd0;
        fin_c.stream_done = 1'b0;
    end

    // output queue
    out_word_t q_mem [QD];
    logic [QW-1:0] wp_reg, rp_reg;
    logic [QW:0]   cnt_reg;
    logic [QW:0]   infl;
    logic [1:0]    nw;
    logic          pop;

    always_comb
    begin
        infl = '0;
        for (int i = 0; i < PL; i++)
            infl = infl + (QW+1)'(tag_reg[i].frame) + (QW+1)'(tag_reg[i].done);
    end
    assign nw  = 2'(fin_frame) + 2'(fin_done);
    assign pop = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (cnt_reg + infl) <= (QW+1)'(QD - 2);

    always_ff @(posedge clk)
    begin
        if (fin_frame)
            q_mem[wp_reg] <= fin_c;
        if (fin_done)
            q_mem[fin_frame ? wp_reg + QW'(1) : wp_reg] <= '{stream_done: 1'b1, default: '0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + QW'(nw);
            if (pop)
                rp_reg <= rp_reg + QW'(1);
            cnt_reg <= cnt_reg + (QW+1)'(nw) - (QW+1)'(pop);
        end
    end

    assign out_ch.valid = cnt_reg != '0;
    assign out_ch.data  = q_mem[rp_reg];

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QW+1)'(QD)) else $error("queue overflow");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eos |=> phase_reg == PH_ID && pos_reg == '0) else $error("eos clear");
    a_emit_block: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> phase_reg == PH_BLOCK) else $error("emit outside block");
endmodule
`default_nettype wire

@@ dv/testbench.sv @@
module testbench;
    import evfe_pkg::*;

    typedef struct packed {
        in_word_t w;
        logic     typed_done;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [63:0] cfg_wdata = 64'd0;

    evfe_in_if  in_ch ();
    evfe_out_if out_ch ();

    ebml_video_frame_extractor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    always #4 clk = ~clk;

    // predictor state
    logic [63:0] sys_offset;
    phase_t      ph;
    logic [3:0]  fcount, ftotal;
    logic [63:0] elem_id, size_acc, value_acc;
    logic [55:0] remaining;
    logic [39:0] pos, elem_start;
    logic [63:0] scale_us, clus_tc;
    logic [39:0] clus_off, codec_off;
    logic [31:0] width_v, height_v;
    logic [55:0] codec_len;
    logic [31:0] blk_hdr;

    out_word_t record_q[$];
    stim_t     byte_q[$];
    stim_t     stream_buf[$];
    int        send_idle = 0, recv_stall = 0;
    int        n_bytes = 0, n_frames = 0, n_done = 0, n_bad = 0;
    int        n_queued = 0;
    int        cycles = 0;
    logic      cur_typed = 1'b0;

    function automatic logic [3:0] vint_bytes(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd1;
        while (n < 4'd8 && b[8 - n] == 1'b0)
            n = n + 4'd1;
        return n;
    endfunction

    function automatic logic [63:0] drop_marker(input logic [63:0] v);
        for (int i = 63; i >= 0; i--)
        begin
            if (v[i])
            begin
                v[i] = 1'b0;
                return v;
            end
        end
        return v;
    endfunction

    task automatic clear_parse();
        ph = PH_ID; fcount = 0; ftotal = 0; elem_id = 0; size_acc = 0;
        remaining = 0; value_acc = 0; pos = 0; elem_start = 0; blk_hdr = 0;
    endtask

    task automatic apply_leaf(input logic [63:0] v);
        if (elem_id == ID_SCALE) scale_us = v;
        else if (elem_id == ID_TIMECODE) clus_tc = v;
        else if (elem_id == ID_PIXWIDTH) width_v = v[31:0];
        else if (elem_id == ID_PIXHEIGHT) height_v = v[31:0];
    endtask

    // header complete: choose where the payload goes
    task automatic enter_payload(input logic [39:0] nxt);
        remaining = size_acc[55:0];
        if (elem_id == ID_SEGMENT || elem_id == ID_INFO || elem_id == ID_CLUSTER ||
            elem_id == ID_TRACKS || elem_id == ID_TRACKENTRY || elem_id == ID_VIDEO)
        begin
            if (elem_id == ID_CLUSTER) clus_off = elem_start;
            ph = PH_ID;
        end
        else if (elem_id == ID_SCALE || elem_id == ID_TIMECODE ||
                 elem_id == ID_PIXWIDTH || elem_id == ID_PIXHEIGHT)
        begin
            value_acc = 0;
            if (size_acc == 0)
            begin
                apply_leaf(64'd0);
                ph = PH_ID;
            end
            else ph = PH_VALUE;
        end
        else if (elem_id == ID_CODECPRIV)
        begin
            elem_start = nxt;
            if (size_acc == 0)
            begin
                codec_off = nxt; codec_len = 0; ph = PH_ID;
            end
            else ph = PH_CODEC;
        end
        else if (elem_id == ID_SIMPLEBLK)
        begin
            elem_start = nxt; blk_hdr = 0;
            ph = (size_acc == 0) ? PH_ID : PH_BLOCK;
        end
        else ph = (size_acc == 0) ? PH_ID : PH_SKIP;
        fcount = 0;
    endtask

    task automatic push_frame();
        out_word_t r;
        logic [63:0] tc, pts;
        tc = {{48{blk_hdr[23]}}, blk_hdr[23:8]};
        pts = (clus_tc + tc) * (scale_us / US_PER_MS);
        r = '0;
        r.presentation_time = pts;
        r.system_time = (sys_offset != 0) ? pts + sys_offset : 64'd0;
        r.payload_offset = elem_start + 40'd4;
        r.payload_length = 56'(size_acc - 64'd4);
        r.cluster_start = clus_off;
        r.key_flag = blk_hdr[7];
        r.wrong_track = (blk_hdr[31:24] != TRACK_ONE);
        r.pixel_width = width_v;
        r.pixel_height = height_v;
        r.codec_data_offset = codec_off;
        r.codec_data_length = codec_len;
        record_q.push_back(r);
    endtask

    task automatic predict_word(input in_word_t w);
        logic [7:0]  b;
        logic [39:0] nxt;
        logic [63:0] acc;
        logic        fin;
        out_word_t   d;
        b = w.data_byte;
        nxt = pos + 40'd1;
        fin = 1'b0;
        if (ph > PH_SKIP)
        begin
            ph = PH_ID; fcount = 0;
        end
        case (ph)
            PH_ID, PH_SIZE:
            begin
                acc = (ph == PH_ID) ? elem_id : size_acc;
                if (fcount == 0)
                begin
                    if (ph == PH_ID) elem_start = pos;
                    acc = {56'd0, b};
                    if (b == 8'd0) fin = 1'b1;
                    else
                    begin
                        ftotal = vint_bytes(b); fcount = 1; fin = (fcount >= ftotal);
                    end
                end
                else
                begin
                    acc = (acc << 8) | b;
                    fcount = fcount + 4'd1;
                    fin = (fcount >= ftotal);
                end
                if (ph == PH_ID)
                begin
                    elem_id = acc;
                    if (fin)
                    begin
                        fcount = 0; ph = PH_SIZE;
                    end
                end
                else
                begin
                    size_acc = acc;
                    if (fin)
                    begin
                        size_acc = drop_marker(acc);
                        size_acc[63:56] = 8'd0;
                        enter_payload(nxt);
                    end
                end
            end
            PH_VALUE:
            begin
                value_acc = (value_acc << 8) | b;
                remaining = remaining - 56'd1;
                if (remaining == 0)
                begin
                    apply_leaf(value_acc); ph = PH_ID;
                end
            end
            PH_CODEC:
            begin
                remaining = remaining - 56'd1;
                if (remaining == 0)
                begin
                    codec_off = elem_start; codec_len = size_acc[55:0]; ph = PH_ID;
                end
            end
            PH_BLOCK:
            begin
                if (56'(size_acc[55:0] - remaining) < 56'd4)
                    blk_hdr = (blk_hdr << 8) | b;
                remaining = remaining - 56'd1;
                if (remaining == 0)
                begin
                    if (size_acc >= 64'd4) push_frame();
                    ph = PH_ID;
                end
            end
            default:
            begin
                remaining = remaining - 56'd1;
                if (remaining == 0) ph = PH_ID;
            end
        endcase
        pos = nxt;
        if (w.end_of_stream)
        begin
            d = '0;
            d.stream_done = 1'b1;
            record_q.push_back(d);
            clear_parse();
        end
    endtask

    // byte driver, predictor hook and record checker
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_word(in_ch.data);
                n_bytes++;
                // typed-in rows: the last record must be a plain done record
                if (cur_typed)
                begin
                    record_q[record_q.size() - 1] = '0;
                    record_q[record_q.size() - 1].stream_done = 1'b1;
                end
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    stim_t s;
                    s = byte_q.pop_front();
                    in_ch.data <= s.w;
                    cur_typed <= s.typed_done;
                    in_ch.valid <= 1'b1;
                end
                else in_ch.valid <= 1'b0;
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
            if (out_ch.valid && out_ch.ready)
            begin
                if (record_q.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10) $display("unexpected record %h", out_ch.data);
                end
                else
                begin
                    out_word_t e;
                    e = record_q.pop_front();
                    if (e.stream_done) n_done++; else n_frames++;
                    if (out_ch.data !== e)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("record mismatch\n  exp %p\n  got %p", e, out_ch.data);
                    end
                end
            end
        end
    end

    // stream builders
    task automatic put(input logic [7:0] b, input logic typed = 1'b0);
        stim_t s;
        s.w.data_byte = b; s.w.end_of_stream = 1'b0; s.typed_done = typed;
        stream_buf.push_back(s);
    endtask

    task automatic put_id(input logic [63:0] id);
        int nb;
        nb = 1;
        while (nb < 8 && (id >> (8 * nb)) != 0) nb++;
        for (int i = nb - 1; i >= 0; i--) put(id[8 * i +: 8]);
    endtask

    task automatic put_size(input logic [55:0] sz);
        int len;
        logic [63:0] v;
        len = 1;
        while (len < 8 && sz >= ((64'd1 << (7 * len)) - 1)) len++;
        if (len < 8 && $urandom_range(3) == 0) len = $urandom_range(8, len);
        v = {8'd0, sz} | (64'd1 << (7 * len));
        for (int i = len - 1; i >= 0; i--) put(v[8 * i +: 8]);
    endtask

    task automatic put_leaf(input logic [63:0] id);
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(9, 0) : $urandom_range(4, 1);
        put_id(id); put_size(n);
        for (int i = 0; i < n; i++) put(8'($urandom_range(255)));
    endtask

    task automatic put_block();
        int n;
        n = ($urandom_range(5) == 0) ? $urandom_range(3) : $urandom_range(12, 4);
        put_id(ID_SIMPLEBLK); put_size(n);
        for (int i = 0; i < n; i++)
            put((i == 0 && $urandom_range(3) != 0) ? TRACK_ONE : 8'($urandom_range(255)));
    endtask

    task automatic put_master(input logic [63:0] id);
        put_id(id);
        if ($urandom_range(1)) put(8'hFF);
        else put_size($urandom_range(200));
    endtask

    // hand the built stream to the driver, maybe cut short
    task automatic flush_stream();
        int len;
        len = stream_buf.size();
        if ($urandom_range(4) == 0) len = $urandom_range(len, 1);
        stream_buf[len - 1].w.end_of_stream = 1'b1;
        for (int i = 0; i < len; i++) byte_q.push_back(stream_buf[i]);
        n_queued += len;
        stream_buf.delete();
    endtask

    task automatic random_stream();
        put_id(64'h1A45DFA3); put_size(3); put(8'h42); put(8'h86); put(8'h81);
        put_master(ID_SEGMENT);
        put_master(ID_INFO);
        put_id(ID_SCALE); put_size(3);
        put(8'h0F); put(8'h42); put(8'h40);
        if ($urandom_range(2) == 0) put_leaf(ID_SCALE);
        put_master(ID_TRACKS); put_master(ID_TRACKENTRY);
        put_leaf(64'hD7); put_leaf(64'h83); put_leaf(64'h86);
        if ($urandom_range(1)) put_leaf(ID_CODECPRIV);
        put_leaf(64'h63A3);
        put_master(ID_VIDEO); put_leaf(ID_PIXWIDTH); put_leaf(ID_PIXHEIGHT);
        for (int c = 0; c < $urandom_range(2, 1); c++)
        begin
            put_master(ID_CLUSTER); put_leaf(ID_TIMECODE);
            for (int k = 0; k < $urandom_range(4, 1); k++)
            begin
                if ($urandom_range(5) == 0) put(8'($urandom_range(255)));
                put_block();
            end
        end
        flush_stream();
    endtask

    task automatic noise_stream();
        for (int i = 0; i < $urandom_range(30, 4); i++) put(8'($urandom_range(255)));
        flush_stream();
    endtask

    task automatic drain();
        while (byte_q.size() > 0 || in_ch.valid || record_q.size() > 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_offset(input logic [63:0] v);
        @(posedge clk);
        cfg_we <= 1'b1; cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sys_offset = v;
    endtask

    // timeout watchdog
    always @(posedge clk)
    begin
        if (cycles > 400000)
        begin
            $display("timeout with %0d records pending", record_q.size());
            $display("ebml_video_frame_extractor_unit test failed");
            $finish;
        end
    end

    logic [7:0] dir_bytes[] = '{
        8'h00,
        8'h2A, 8'hD7, 8'hB1, 8'h82, 8'h03, 8'hE8,
        8'h1F, 8'h43, 8'hB6, 8'h75, 8'h80,
        8'hE7, 8'h81, 8'h05,
        8'hA3, 8'h84, 8'h81, 8'hFF, 8'hFF, 8'h80,
        8'hA3, 8'h82, 8'h00, 8'h00
    };

    logic [63:0] offsets[] = '{64'd0, 64'h7FFFFFFFFFFFFFFF, 64'h8000000000000000,
                               64'hFFFFFFFFFFFFFFFF};

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        sys_offset = 0;
        scale_us = 0; clus_tc = 0; clus_off = 0; width_v = 0; height_v = 0;
        codec_off = 0; codec_len = 0;
        clear_parse();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone end byte, scale, empty cluster, key block, short block
        set_offset(64'd100);
        put(dir_bytes[0], 1'b1);
        stream_buf[0].w.end_of_stream = 1'b1;
        byte_q.push_back(stream_buf.pop_front());
        for (int i = 1; i < dir_bytes.size(); i++) put(dir_bytes[i]);
        put(8'h63); put(8'hA2); put(8'h80, 1'b1);
        stream_buf[stream_buf.size() - 1].w.end_of_stream = 1'b1;
        while (stream_buf.size() > 0) byte_q.push_back(stream_buf.pop_front());
        drain();

        // random streams over idle phases and offset settings
        for (int p = 0; p < 4; p++)
        begin
            int base;
            int s;
            base = n_queued;
            s = 0;
            send_idle  = (p == 1) ? 67 : (p == 3) ? 22 : 0;
            recv_stall = (p == 2) ? 67 : (p == 3) ? 22 : 0;
            while (n_queued - base < 400)
            begin
                if (s == 0) set_offset(offsets[$urandom_range(3)]);
                else if (s == 2) set_offset({$urandom, $urandom});
                if ($urandom_range(5) == 0) noise_stream();
                else random_stream();
                drain();
                s++;
            end
        end
        send_idle = 0; recv_stall = 0;
        drain();

        $display("sent %0d bytes; checked %0d frame and %0d done records",
                 n_bytes, n_frames, n_done);
        if (n_bad == 0)
            $display("ebml_video_frame_extractor_unit test passed");
        else
            $display("ebml_video_frame_extractor_unit test failed");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/evfe_pkg.sv
rtl/core/evfe_if.sv
rtl/core/ebml_video_frame_extractor_unit.sv
dv/testbench.sv
